>>> src/rss_pkg.sv
// ---------------------------------------------------------------------------
// rss_pkg: shared types and constants for the radio scan sequencer
// Request codes, register map, skip test constants.
// ---------------------------------------------------------------------------
package rss_pkg;

    typedef enum logic [2:0] {
        REQ_START  = 3'd0,
        REQ_TUNE   = 3'd1,
        REQ_CHECK  = 3'd2,
        REQ_POLL   = 3'd3,
        REQ_TAIL   = 3'd4,
        REQ_SKIP   = 3'd5
    } req_code_t;

    typedef enum logic [2:0] {
        REG_RANGE_START    = 3'd0,
        REG_RANGE_END      = 3'd1,
        REG_STEP_SIZE      = 3'd2,
        REG_DETECT_MARGIN  = 3'd3,
        REG_OPEN_TIMEOUT   = 3'd4,
        REG_CLOSED_TIMEOUT = 3'd5,
        REG_MODE_FLAGS     = 3'd6,
        REG_POLL_INTERVAL  = 3'd7
    } reg_index_t;

    localparam int unsigned FREQ_W   = 28;
    localparam int unsigned OUT_FREQ_W = 27;
    localparam int unsigned ADDR_W   = 5;

    localparam logic [31:0] TAIL_GATE_MS = 32'd250;

    // garbage channel: multiple of 650000 = 2^4 * 40625
    localparam int unsigned GARBAGE_STEP = 650000;
    localparam int unsigned GARB_SHIFT   = 4;
    localparam int unsigned GARB_ODD     = GARBAGE_STEP >> GARB_SHIFT;
    localparam int unsigned GARB_W       = FREQ_W - GARB_SHIFT;
    localparam int unsigned GARB_LIMIT   = ((2 ** GARB_W) - 1) / GARB_ODD;

    // inverse of an odd value modulo 2^24 (Newton iteration)
    function automatic logic [23:0] odd_inverse(input logic [23:0] a);
        logic [23:0] x;
        x = a;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (24'd2 - a * x);
        end
        return x;
    endfunction

    localparam logic [23:0] GARB_INV = odd_inverse(24'(GARB_ODD));

endpackage

>>> src/radio_scan_sequencer.sv
// ---------------------------------------------------------------------------
// radio_scan_sequencer: frequency scan sequencer
// Sweeps a frequency range with skip, noise floor tracking, check and listen.
// ---------------------------------------------------------------------------
// One request beat yields one result beat. A new request is taken every
// cycle unless a result waits untaken; a request passes the input register,
// then one pass of sequencer logic into the result register. The longest
// path is the garbage channel test: a 24x24 multiply by the modular inverse
// of the odd part of the garbage step, a compare, then next-state selection.
// Configuration must be written over the APB port only while no request is
// in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module radio_scan_sequencer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [8:0]  rssi_level,
    input  logic        freq_listed,
    input  logic        squelch_open,
    input  logic [31:0] now_ms,

    output logic        res_valid,
    input  logic        res_ready,
    output logic [26:0] tune_freq,
    output logic [1:0]  scan_phase,
    output logic        audio_open,
    output logic [8:0]  noise_floor,
    output logic        range_wrapped,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_TUNING    = 2'd1,
        PH_CHECKING  = 2'd2,
        PH_LISTENING = 2'd3
    } phase_t;

    // configuration
    logic [26:0] range_start_reg;
    logic [26:0] range_end_reg;
    logic [19:0] step_size_reg;
    logic [5:0]  margin_reg;
    logic [31:0] open_to_reg;
    logic [31:0] closed_to_reg;
    logic [2:0]  mode_reg;
    logic [15:0] poll_int_reg;

    // input stage
    logic        in_valid_reg;
    logic [2:0]  in_type_reg;
    logic [8:0]  in_rssi_reg;
    logic        in_listed_reg;
    logic        in_sq_reg;
    logic [31:0] in_now_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [27:0] freq_reg, freq_next;
    logic [8:0]  floor_reg, floor_next;
    logic [31:0] entered_reg, entered_next;
    logic [31:0] closed_since_reg, closed_since_next;
    logic        closed_valid_reg, closed_valid_next;
    logic [31:0] reopen_reg, reopen_next;
    logic [31:0] last_poll_reg, last_poll_next;
    logic        listen_reg, listen_next;
    logic        wrapped_next;

    logic        out_valid_reg;
    logic        fire;
    logic        cfg_write;

    logic [23:0] garb_prod;
    logic        garbage;
    logic        skippable;
    logic [27:0] freq_adv;
    logic        past_end;
    logic        adv_past_end;
    logic [8:0]  floor_upd;
    logic [9:0]  threshold;
    logic [31:0] gate_time;
    logic        poll_due;
    logic        open_now;
    logic        leave;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign fire      = in_valid_reg && (!out_valid_reg || res_ready);
    assign req_ready = !in_valid_reg || fire;
    assign res_valid = out_valid_reg;

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= 27'd0;
            range_end_reg   <= 27'h7FFFFFF;
            step_size_reg   <= 20'd2500;
            margin_reg      <= 6'd12;
            open_to_reg     <= 32'd10000;
            closed_to_reg   <= 32'd3000;
            mode_reg        <= 3'd2;
            poll_int_reg    <= 16'd60;
        end
        else if (cfg_write)
        begin
            unique case (rss_pkg::reg_index_t'(paddr[4:2]))
                rss_pkg::REG_RANGE_START:    range_start_reg <= pwdata[26:0];
                rss_pkg::REG_RANGE_END:      range_end_reg   <= pwdata[26:0];
                rss_pkg::REG_STEP_SIZE:      step_size_reg   <= pwdata[19:0];
                rss_pkg::REG_DETECT_MARGIN:  margin_reg      <= pwdata[5:0];
                rss_pkg::REG_OPEN_TIMEOUT:   open_to_reg     <= pwdata;
                rss_pkg::REG_CLOSED_TIMEOUT: closed_to_reg   <= pwdata;
                rss_pkg::REG_MODE_FLAGS:     mode_reg        <= pwdata[2:0];
                rss_pkg::REG_POLL_INTERVAL:  poll_int_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (rss_pkg::reg_index_t'(paddr[4:2]))
            rss_pkg::REG_RANGE_START:    prdata = {5'd0, range_start_reg};
            rss_pkg::REG_RANGE_END:      prdata = {5'd0, range_end_reg};
            rss_pkg::REG_STEP_SIZE:      prdata = {12'd0, step_size_reg};
            rss_pkg::REG_DETECT_MARGIN:  prdata = {26'd0, margin_reg};
            rss_pkg::REG_OPEN_TIMEOUT:   prdata = open_to_reg;
            rss_pkg::REG_CLOSED_TIMEOUT: prdata = closed_to_reg;
            rss_pkg::REG_MODE_FLAGS:     prdata = {29'd0, mode_reg};
            rss_pkg::REG_POLL_INTERVAL:  prdata = {16'd0, poll_int_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---- input register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_type_reg   <= req_type;
            in_rssi_reg   <= rssi_level;
            in_listed_reg <= freq_listed;
            in_sq_reg     <= squelch_open;
            in_now_reg    <= now_ms;
        end
    end

    // ---- shared terms ----
    assign garb_prod = freq_reg[27:rss_pkg::GARB_SHIFT] * rss_pkg::GARB_INV;
    assign garbage   = mode_reg[1] && (freq_reg[rss_pkg::GARB_SHIFT-1:0] == '0)
                       && (garb_prod <= 24'(rss_pkg::GARB_LIMIT));
    assign skippable = garbage || in_listed_reg;

    assign freq_adv     = freq_reg + {8'd0, step_size_reg};
    assign past_end     = freq_reg > {1'b0, range_end_reg};
    assign adv_past_end = freq_adv > {1'b0, range_end_reg};

    assign floor_upd = (in_rssi_reg < floor_reg) ? in_rssi_reg
                     : floor_reg + ((in_rssi_reg - floor_reg) >> 3);
    assign threshold = {1'b0, floor_upd} + {4'd0, margin_reg};

    assign gate_time = in_now_reg + rss_pkg::TAIL_GATE_MS;
    assign poll_due  = (in_now_reg - last_poll_reg) >= {16'd0, poll_int_reg};
    assign open_now  = in_sq_reg && (in_now_reg >= reopen_reg);

    // ---- next state ----
    always_comb
    begin
        phase_next        = phase_reg;
        freq_next         = freq_reg;
        floor_next        = floor_reg;
        closed_since_next = closed_since_reg;
        closed_valid_next = closed_valid_reg;
        reopen_next       = reopen_reg;
        last_poll_next    = last_poll_reg;
        listen_next       = listen_reg;
        wrapped_next      = 1'b0;
        leave             = 1'b0;

        unique case (in_type_reg)
            rss_pkg::REQ_START:
            begin
                freq_next         = {1'b0, range_start_reg};
                listen_next       = 1'b0;
                closed_valid_next = 1'b0;
                phase_next        = PH_TUNING;
            end
            rss_pkg::REQ_TUNE:
            begin
                if (phase_reg == PH_TUNING)
                begin
                    priority if (skippable && step_size_reg == '0)
                    begin
                        freq_next    = {1'b0, range_start_reg};
                        wrapped_next = 1'b1;
                    end
                    else if (skippable && !past_end)
                    begin
                        if (adv_past_end)
                        begin
                            freq_next    = {1'b0, range_start_reg};
                            wrapped_next = 1'b1;
                        end
                        else
                        begin
                            freq_next = freq_adv;
                        end
                    end
                    else if (past_end)
                    begin
                        freq_next    = {1'b0, range_start_reg};
                        wrapped_next = 1'b1;
                    end
                    else if (mode_reg[0])
                    begin
                        freq_next = freq_adv;
                    end
                    else
                    begin
                        floor_next = floor_upd;
                        if ({1'b0, in_rssi_reg} <= threshold)
                        begin
                            freq_next = freq_adv;
                        end
                        else
                        begin
                            phase_next = PH_CHECKING;
                        end
                    end
                end
            end
            rss_pkg::REQ_CHECK:
            begin
                if (phase_reg == PH_CHECKING)
                begin
                    if (in_sq_reg)
                    begin
                        listen_next = 1'b1;
                        phase_next  = PH_LISTENING;
                    end
                    else
                    begin
                        freq_next  = freq_adv;
                        phase_next = PH_TUNING;
                    end
                end
            end
            rss_pkg::REQ_POLL:
            begin
                if (phase_reg == PH_LISTENING && poll_due)
                begin
                    last_poll_next = in_now_reg;
                    listen_next    = open_now;
                    if (open_now != listen_reg)
                    begin
                        if (listen_reg)
                        begin
                            if (mode_reg[2])
                            begin
                                reopen_next = gate_time;
                            end
                            closed_since_next = in_now_reg;
                            closed_valid_next = 1'b1;
                        end
                        else
                        begin
                            closed_valid_next = 1'b0;
                        end
                    end
                    if (open_now)
                    begin
                        leave = (in_now_reg - entered_reg) >= open_to_reg;
                    end
                    else
                    begin
                        leave = closed_valid_next
                                && (in_now_reg - closed_since_next) >= closed_to_reg;
                    end
                    if (leave)
                    begin
                        listen_next       = 1'b0;
                        freq_next         = freq_adv;
                        closed_valid_next = 1'b0;
                        phase_next        = PH_TUNING;
                    end
                end
            end
            rss_pkg::REQ_TAIL:
            begin
                if (mode_reg[2])
                begin
                    reopen_next = gate_time;
                end
                listen_next = 1'b0;
            end
            rss_pkg::REQ_SKIP:
            begin
                listen_next = 1'b0;
                freq_next   = freq_adv;
                phase_next  = PH_TUNING;
            end
            default: ;
        endcase

        entered_next = (phase_next != phase_reg) ? in_now_reg : entered_reg;
    end

    // ---- state and result valid ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            freq_reg         <= '0;
            floor_reg        <= 9'd100;
            entered_reg      <= '0;
            closed_since_reg <= '0;
            closed_valid_reg <= 1'b0;
            reopen_reg       <= '0;
            last_poll_reg    <= '0;
            listen_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg        <= phase_next;
                freq_reg         <= freq_next;
                floor_reg        <= floor_next;
                entered_reg      <= entered_next;
                closed_since_reg <= closed_since_next;
                closed_valid_reg <= closed_valid_next;
                reopen_reg       <= reopen_next;
                last_poll_reg    <= last_poll_next;
                listen_reg       <= listen_next;
                out_valid_reg    <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- result payload ----
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tune_freq     <= freq_next[27] ? '1 : freq_next[26:0];
            scan_phase    <= phase_next;
            audio_open    <= listen_next;
            noise_floor   <= floor_next;
            range_wrapped <= wrapped_next;
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for radio_scan_sequencer
// A queue of request beats feeds a valid/ready driver; each accepted beat is
// run through a behavioral model of the scan sequencer and the predicted
// result is queued. A monitor checks every result beat field by field.
// Directed beats run at reset configuration, then random scan episodes run
// under several register settings written over APB, with random stalls.
// ---------------------------------------------------------------------------
module tb;

    typedef enum logic [1:0] {
        PHASE_IDLE      = 2'd0,
        PHASE_TUNING    = 2'd1,
        PHASE_CHECKING  = 2'd2,
        PHASE_LISTENING = 2'd3
    } scan_phase_t;

    localparam logic [2:0]  REQ_RSVD6       = 3'd6;
    localparam logic [2:0]  REQ_RSVD7       = 3'd7;
    localparam logic [27:0] GARBAGE_SPACING = 28'd650000;
    localparam logic [31:0] TAIL_HOLD_MS    = 32'd250;
    localparam logic [27:0] FREQ_OUT_MAX    = 28'h7FFFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [8:0]  rssi;
        logic        listed;
        logic        sq;
        logic [31:0] now;
    } scan_req_t;

    typedef struct packed {
        logic [26:0] freq;
        logic [1:0]  phase;
        logic        audio;
        logic [8:0]  floor_lvl;
        logic        wrapped;
    } scan_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  req_type = rss_pkg::REQ_START;
    logic [8:0]  rssi_level = '0;
    logic        freq_listed = 1'b0;
    logic        squelch_open = 1'b0;
    logic [31:0] now_ms = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [26:0] tune_freq;
    logic [1:0]  scan_phase;
    logic        audio_open;
    logic [8:0]  noise_floor;
    logic        range_wrapped;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    radio_scan_sequencer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .rssi_level    (rssi_level),
        .freq_listed   (freq_listed),
        .squelch_open  (squelch_open),
        .now_ms        (now_ms),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .tune_freq     (tune_freq),
        .scan_phase    (scan_phase),
        .audio_open    (audio_open),
        .noise_floor   (noise_floor),
        .range_wrapped (range_wrapped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register shadow
    logic [26:0] cfg_start     = 27'd0;
    logic [26:0] cfg_end       = 27'h7FFFFFF;
    logic [19:0] cfg_step      = 20'd2500;
    logic [5:0]  cfg_margin    = 6'd12;
    logic [31:0] cfg_open_to   = 32'd10000;
    logic [31:0] cfg_closed_to = 32'd3000;
    logic [2:0]  cfg_mode      = 3'd2;
    logic [15:0] cfg_poll_iv   = 16'd60;

    // sequencer state
    scan_phase_t scan_ph         = PHASE_IDLE;
    logic [27:0] scan_freq       = '0;
    logic [8:0]  floor_est       = 9'd100;
    logic [31:0] entered_ms      = '0;
    logic [31:0] closed_since_ms = '0;
    logic        closed_seen     = 1'b0;
    logic [31:0] reopen_after_ms = '0;
    logic [31:0] last_poll_ms    = '0;
    logic        audio_on        = 1'b0;

    scan_req_t   pending_reqs[$];
    scan_res_t   expected_results[$];
    scan_req_t   req_beat;
    int unsigned items_added = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 56;
    int unsigned ms_stride = 60;
    logic [31:0] clock_ms = '0;
    logic        hold_send = 1'b0;

    function automatic void step_freq();
        scan_freq = scan_freq + 28'(cfg_step);
    endfunction

    function automatic void go_phase(input scan_phase_t p, input logic [31:0] now);
        if (scan_ph != p)
        begin
            scan_ph    = p;
            entered_ms = now;
        end
    endfunction

    function automatic void arm_tail_gate(input logic [31:0] now);
        if (cfg_mode[2])
            reopen_after_ms = now + TAIL_HOLD_MS;
    endfunction

    function automatic scan_res_t predict_scan(input scan_req_t r);
        scan_res_t   o;
        logic        wrapped;
        logic        skip_it;
        logic        was_open;
        logic        leave;
        logic [9:0]  thr;
        logic [31:0] since;
        wrapped = 1'b0;
        case (r.kind)
            rss_pkg::REQ_START:
            begin
                scan_freq   = 28'(cfg_start);
                audio_on    = 1'b0;
                closed_seen = 1'b0;
                go_phase(PHASE_TUNING, r.now);
            end
            rss_pkg::REQ_TUNE:
            if (scan_ph == PHASE_TUNING)
            begin
                skip_it = r.listed || (cfg_mode[1] && (scan_freq % GARBAGE_SPACING) == 0);
                if (skip_it && cfg_step == 0)
                begin
                    scan_freq = 28'(cfg_start);
                    wrapped   = 1'b1;
                end
                else if (skip_it && scan_freq <= 28'(cfg_end))
                begin
                    step_freq();
                    if (scan_freq > 28'(cfg_end))
                    begin
                        scan_freq = 28'(cfg_start);
                        wrapped   = 1'b1;
                    end
                end
                else if (scan_freq > 28'(cfg_end))
                begin
                    scan_freq = 28'(cfg_start);
                    wrapped   = 1'b1;
                end
                else if (cfg_mode[0])
                    step_freq();
                else
                begin
                    if (r.rssi < floor_est)
                        floor_est = r.rssi;
                    else
                        floor_est = floor_est + ((r.rssi - floor_est) >> 3);
                    thr = 10'(floor_est) + 10'(cfg_margin);
                    if (10'(r.rssi) <= thr)
                        step_freq();
                    else
                        go_phase(PHASE_CHECKING, r.now);
                end
            end
            rss_pkg::REQ_CHECK:
            if (scan_ph == PHASE_CHECKING)
            begin
                if (r.sq)
                begin
                    audio_on = 1'b1;
                    go_phase(PHASE_LISTENING, r.now);
                end
                else
                begin
                    step_freq();
                    go_phase(PHASE_TUNING, r.now);
                end
            end
            rss_pkg::REQ_POLL:
            if (scan_ph == PHASE_LISTENING)
            begin
                since = r.now - last_poll_ms;
                if (since >= 32'(cfg_poll_iv))
                begin
                    last_poll_ms = r.now;
                    was_open     = audio_on;
                    audio_on     = r.sq && (r.now >= reopen_after_ms);
                    if (audio_on != was_open)
                    begin
                        if (was_open)
                        begin
                            arm_tail_gate(r.now);
                            closed_since_ms = r.now;
                            closed_seen     = 1'b1;
                        end
                        else
                            closed_seen = 1'b0;
                    end
                    if (audio_on)
                    begin
                        since = r.now - entered_ms;
                        leave = since >= cfg_open_to;
                    end
                    else
                    begin
                        since = r.now - closed_since_ms;
                        leave = closed_seen && since >= cfg_closed_to;
                    end
                    if (leave)
                    begin
                        audio_on    = 1'b0;
                        step_freq();
                        closed_seen = 1'b0;
                        go_phase(PHASE_TUNING, r.now);
                    end
                end
            end
            rss_pkg::REQ_TAIL:
            begin
                arm_tail_gate(r.now);
                audio_on = 1'b0;
            end
            rss_pkg::REQ_SKIP:
            begin
                audio_on = 1'b0;
                step_freq();
                go_phase(PHASE_TUNING, r.now);
            end
            default:
            begin
            end
        endcase
        o.freq      = (scan_freq > FREQ_OUT_MAX) ? FREQ_OUT_MAX[26:0] : scan_freq[26:0];
        o.phase     = scan_ph;
        o.audio     = audio_on;
        o.floor_lvl = floor_est;
        o.wrapped   = wrapped;
        return o;
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive_proc
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_results.push_back(predict_scan(req_beat));
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    req_beat = pending_reqs.pop_front();
                    req_valid    <= 1'b1;
                    req_type     <= req_beat.kind;
                    rssi_level   <= req_beat.rssi;
                    freq_listed  <= req_beat.listed;
                    squelch_open <= req_beat.sq;
                    now_ms       <= req_beat.now;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin : check_proc
        scan_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR result %0d: no beat outstanding", results_seen);
            end
            else
            begin
                want = expected_results.pop_front();
                if (tune_freq !== want.freq || scan_phase !== want.phase
                    || audio_open !== want.audio || noise_floor !== want.floor_lvl
                    || range_wrapped !== want.wrapped)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR result %0d: exp freq=%0d ph=%0d aud=%b flr=%0d wrap=%b",
                                 results_seen, want.freq, want.phase, want.audio,
                                 want.floor_lvl, want.wrapped);
                    if (mismatch_cnt <= 10)
                        $display("    got freq=%0d ph=%0d aud=%b flr=%0d wrap=%b",
                                 tune_freq, scan_phase, audio_open, noise_floor,
                                 range_wrapped);
                end
            end
        end
    end

    task automatic apb_write(input rss_pkg::reg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rss_pkg::REG_RANGE_START:    cfg_start     = val[26:0];
            rss_pkg::REG_RANGE_END:      cfg_end       = val[26:0];
            rss_pkg::REG_STEP_SIZE:      cfg_step      = val[19:0];
            rss_pkg::REG_DETECT_MARGIN:  cfg_margin    = val[5:0];
            rss_pkg::REG_OPEN_TIMEOUT:   cfg_open_to   = val;
            rss_pkg::REG_CLOSED_TIMEOUT: cfg_closed_to = val;
            rss_pkg::REG_MODE_FLAGS:     cfg_mode      = val[2:0];
            rss_pkg::REG_POLL_INTERVAL:  cfg_poll_iv   = val[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input logic [31:0] start, input logic [31:0] stop,
                              input logic [31:0] step, input logic [31:0] margin,
                              input logic [31:0] open_to, input logic [31:0] closed_to,
                              input logic [31:0] mode, input logic [31:0] poll_iv);
        apb_write(rss_pkg::REG_RANGE_START, start);
        apb_write(rss_pkg::REG_RANGE_END, stop);
        apb_write(rss_pkg::REG_STEP_SIZE, step);
        apb_write(rss_pkg::REG_DETECT_MARGIN, margin);
        apb_write(rss_pkg::REG_OPEN_TIMEOUT, open_to);
        apb_write(rss_pkg::REG_CLOSED_TIMEOUT, closed_to);
        apb_write(rss_pkg::REG_MODE_FLAGS, mode);
        apb_write(rss_pkg::REG_POLL_INTERVAL, poll_iv);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_at(input logic [2:0] kind, input logic [8:0] rssi,
                           input logic listed, input logic sq, input logic [31:0] now);
        scan_req_t r;
        r.kind   = kind;
        r.rssi   = rssi;
        r.listed = listed;
        r.sq     = sq;
        r.now    = now;
        pending_reqs.push_back(r);
        items_added++;
    endtask

    task automatic push_rand(input logic [2:0] kind, input logic [8:0] rssi,
                             input logic listed, input logic sq);
        if ($urandom_range(49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, ms_stride);
        push_at(kind, rssi, listed, sq, clock_ms);
    endtask

    function automatic logic [8:0] pick_rssi();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 6)
            return 9'($urandom_range(60, 150));
        else if (roll < 9)
            return 9'($urandom_range(200, 511));
        return 9'($urandom_range(0, 511));
    endfunction

    // optional start, a few channels, one strong hit, check, then a run of polls
    task automatic add_episode();
        int unsigned n_tune;
        int unsigned n_poll;
        logic        sq;
        if ($urandom_range(1) == 0)
            push_rand(rss_pkg::REQ_START, pick_rssi(), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        n_tune = $urandom_range(0, 5);
        repeat (n_tune)
            push_rand(rss_pkg::REQ_TUNE, pick_rssi(), $urandom_range(7) == 0,
                      1'($urandom_range(1)));
        push_rand(rss_pkg::REQ_TUNE, 9'($urandom_range(300, 511)),
                  $urandom_range(15) == 0, 1'($urandom_range(1)));
        push_rand(rss_pkg::REQ_CHECK, pick_rssi(), 1'($urandom_range(1)),
                  $urandom_range(9) < 7);
        n_poll = $urandom_range(1, 10);
        sq = 1'b1;
        repeat (n_poll)
        begin
            if ($urandom_range(9) < 3)
                sq = ~sq;
            if ($urandom_range(11) == 0)
                push_rand(rss_pkg::REQ_TAIL, pick_rssi(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            push_rand(rss_pkg::REQ_POLL, pick_rssi(), 1'($urandom_range(1)), sq);
        end
    endtask

    task automatic gen_phase(input int unsigned n);
        int unsigned goal;
        goal = items_added + n;
        while (items_added < goal)
        begin
            if ($urandom_range(99) < 85)
                add_episode();
            else
                push_rand(3'($urandom_range(7)), 9'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats at reset configuration
        push_at(rss_pkg::REQ_TUNE, 9'd511, 1'b0, 1'b1, 32'd0);
        push_at(rss_pkg::REQ_CHECK, 9'd0, 1'b1, 1'b1, 32'd10);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b1, 32'd20);
        push_at(REQ_RSVD6, 9'd511, 1'b1, 1'b1, 32'd30);
        push_at(REQ_RSVD7, 9'd0, 1'b0, 1'b0, 32'd40);
        push_at(rss_pkg::REQ_START, 9'd0, 1'b0, 1'b0, 32'd0);
        push_at(rss_pkg::REQ_TUNE, 9'd511, 1'b0, 1'b0, 32'd100);
        push_at(rss_pkg::REQ_TUNE, 9'd511, 1'b1, 1'b0, 32'd110);
        push_at(rss_pkg::REQ_TUNE, 9'd0, 1'b0, 1'b0, 32'd120);
        push_at(rss_pkg::REQ_TUNE, 9'd5, 1'b0, 1'b0, 32'd130);
        push_at(rss_pkg::REQ_TUNE, 9'd511, 1'b0, 1'b0, 32'd140);
        push_at(rss_pkg::REQ_CHECK, 9'd0, 1'b0, 1'b0, 32'd150);
        push_at(rss_pkg::REQ_TUNE, 9'd511, 1'b0, 1'b0, 32'd160);
        push_at(rss_pkg::REQ_CHECK, 9'd0, 1'b0, 1'b1, 32'd1000);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b1, 32'd1030);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b1, 32'd1050);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b0, 32'd1100);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b1, 32'd1200);
        push_at(rss_pkg::REQ_TAIL, 9'd0, 1'b0, 1'b1, 32'd1250);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b0, 32'd1400);
        push_at(rss_pkg::REQ_POLL, 9'd0, 1'b0, 1'b1, 32'd11500);
        push_at(rss_pkg::REQ_SKIP, 9'd0, 1'b0, 1'b0, 32'd11600);
        push_at(rss_pkg::REQ_START, 9'd511, 1'b1, 1'b1, 32'hFFFFFFFF);
        push_at(rss_pkg::REQ_TUNE, 9'd511, 1'b0, 1'b1, 32'hFFFFFFFF);

        // near a garbage channel, short timeouts
        wait_drained();
        set_config(32'd1295000, 32'd1445000, 32'd2500, 32'd12, 32'd400, 32'd150,
                   32'd2, 32'd20);
        ms_stride = 60;
        gen_phase(300);

        // single channel, zero timeouts, gate on
        wait_drained();
        set_config(32'd5000000, 32'd5000000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd6, 32'd0);
        ms_stride = 400;
        gen_phase(300);

        // top of the band, largest step, longest timeouts
        wait_drained();
        send_idle_pct = 56;
        recv_idle_pct = 16;
        set_config(32'd134217627, 32'd134217727, 32'd1048575, 32'd63, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 32'd4, 32'd65535);
        ms_stride = 140000;
        gen_phase(160);
        repeat (140)
            push_rand(rss_pkg::REQ_SKIP, pick_rssi(), 1'($urandom_range(1)),
                      1'($urandom_range(1)));

        // analyser sweep landing on garbage channels, with a full drain mid-run
        wait_drained();
        set_config(32'd0, 32'd134217727, 32'd650000, 32'd5, 32'd1000, 32'd300, 32'd3,
                   32'd100);
        ms_stride = 150;
        gen_phase(300);
        @(posedge clk);
        while (pending_reqs.size() > 150)
            @(posedge clk);
        hold_send <= 1'b1;
        @(posedge clk);
        while (req_valid || expected_results.size() != 0)
            @(posedge clk);
        hold_send <= 1'b0;

        // random registers
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config($urandom_range(0, 134217727), $urandom_range(0, 134217727),
                   $urandom_range(0, 1048575), $urandom_range(0, 63),
                   $urandom_range(0, 2000), $urandom_range(0, 2000),
                   $urandom_range(0, 7), $urandom_range(0, 100));
        ms_stride = $urandom_range(20, 300);
        gen_phase(300);

        wait_drained();
        set_config(32'd100000, 32'd400000, 32'd12500, 32'd20, 32'd300, 32'd120, 32'd6,
                   32'd30);
        ms_stride = 50;
        gen_phase(300);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
